### src/sha256_pkg.sv
package sha256_pkg;

    typedef enum logic [1:0] {
        SEL_MSG,
        SEL_PAD80,
        SEL_ZERO,
        SEL_LEN
    } t_byte_sel;

    typedef struct packed {
        logic       absorb;
        t_byte_sel  sel;
        logic       count;
        logic       clr_total;
        logic       load;
        logic       round;
        logic [5:0] round_idx;
        logic       finish;
        logic       digest;
    } t_dp_cmd;

    typedef struct packed {
        logic [5:0] fill;
        logic       out_busy;
    } t_dp_sts;

    localparam logic [7:0] PAD_BYTE     = 8'h80;
    localparam logic [5:0] LEN_START    = 6'd56;
    localparam logic [5:0] LAST_SLOT    = 6'd63;
    localparam logic [5:0] LAST_ROUND   = 6'd63;
    localparam logic [3:0] DIGEST_WORDS = 4'd8;
    localparam logic [2:0] LAST_INDEX   = 3'd7;

    localparam logic [31:0] IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

endpackage

### src/sha256_in_if.sv
interface sha256_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;

    modport source (output valid, output data_byte, output byte_present,
                    output end_of_message, input ready);
    modport sink (input valid, input data_byte, input byte_present,
                  input end_of_message, output ready);
endinterface

### src/sha256_out_if.sv
interface sha256_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    modport source (output valid, output digest_word, output word_index,
                    output last_word, input ready);
    modport sink (input valid, input digest_word, input word_index,
                  input last_word, output ready);
endinterface

### src/sha256_dp.sv
module sha256_dp
    import sha256_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dp_cmd     i_cmd,
    input  logic [7:0]  i_data_byte,
    output t_dp_sts     o_sts,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);

    function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned n);
        rotr = (v >> n) | (v << (32 - n));
    endfunction

    logic [511:0] r_collect;
    logic [511:0] r_win;
    logic [31:0]  r_wv [8];
    logic [31:0]  r_h [8];
    logic [255:0] r_obuf;
    logic [5:0]   r_fill;
    logic [60:0]  r_total;
    logic [3:0]   r_ocnt;
    logic [2:0]   r_oidx;

    logic [7:0]   byte_in;
    logic [63:0]  len_shift;
    logic [31:0]  w0, w1, w9, w14, w_new;
    logic [31:0]  s0, s1, ch, maj, t1, t2;
    logic         out_fire;

    // length field, big-endian, one byte per slot from 56 to 63
    assign len_shift = {r_total, 3'b000} << {r_fill[2:0], 3'b000};

    always_comb begin
        case (i_cmd.sel)
            SEL_MSG:   byte_in = i_data_byte;
            SEL_PAD80: byte_in = PAD_BYTE;
            SEL_ZERO:  byte_in = 8'h00;
            SEL_LEN:   byte_in = len_shift[63:56];
            default:   byte_in = 8'h00;
        endcase
    end

    // schedule window: oldest word at the top
    assign w0  = r_win[511:480];
    assign w1  = r_win[479:448];
    assign w9  = r_win[223:192];
    assign w14 = r_win[63:32];
    assign w_new = w0 + w9
                 + (rotr(w1, 7) ^ rotr(w1, 18) ^ (w1 >> 3))
                 + (rotr(w14, 17) ^ rotr(w14, 19) ^ (w14 >> 10));

    assign s1  = rotr(r_wv[4], 6) ^ rotr(r_wv[4], 11) ^ rotr(r_wv[4], 25);
    assign ch  = (r_wv[4] & r_wv[5]) ^ (~r_wv[4] & r_wv[6]);
    assign s0  = rotr(r_wv[0], 2) ^ rotr(r_wv[0], 13) ^ rotr(r_wv[0], 22);
    assign maj = (r_wv[0] & r_wv[1]) ^ (r_wv[0] & r_wv[2]) ^ (r_wv[1] & r_wv[2]);
    assign t1  = r_wv[7] + s1 + ch + K[i_cmd.round_idx] + w0;
    assign t2  = s0 + maj;

    assign out_fire = o_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill  <= '0;
            r_total <= '0;
            r_ocnt  <= '0;
            r_oidx  <= '0;
            for (int i = 0; i < 8; i++) r_h[i] <= IV[i];
        end else begin
            if (i_cmd.absorb) r_fill <= r_fill + 6'd1;
            if (i_cmd.clr_total) r_total <= '0;
            else if (i_cmd.count) r_total <= r_total + 61'd1;
            if (i_cmd.finish) begin
                for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_wv[i];
            end else if (i_cmd.digest) begin
                for (int i = 0; i < 8; i++) r_h[i] <= IV[i];
            end
            if (i_cmd.digest) begin
                r_ocnt <= DIGEST_WORDS;
                r_oidx <= '0;
            end else if (out_fire) begin
                r_ocnt <= r_ocnt - 4'd1;
                r_oidx <= r_oidx + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.absorb) r_collect <= {r_collect[503:0], byte_in};
        if (i_cmd.load) begin
            r_win <= r_collect;
            for (int i = 0; i < 8; i++) r_wv[i] <= r_h[i];
        end else if (i_cmd.round) begin
            r_win   <= {r_win[479:0], w_new};
            r_wv[7] <= r_wv[6];
            r_wv[6] <= r_wv[5];
            r_wv[5] <= r_wv[4];
            r_wv[4] <= r_wv[3] + t1;
            r_wv[3] <= r_wv[2];
            r_wv[2] <= r_wv[1];
            r_wv[1] <= r_wv[0];
            r_wv[0] <= t1 + t2;
        end
        if (i_cmd.digest) begin
            r_obuf <= {r_h[0], r_h[1], r_h[2], r_h[3], r_h[4], r_h[5], r_h[6], r_h[7]};
        end else if (out_fire) begin
            r_obuf <= {r_obuf[223:0], 32'h0000_0000};
        end
    end

    assign o_sts.fill     = r_fill;
    assign o_sts.out_busy = (r_ocnt != 4'd0);
    assign o_out_valid    = (r_ocnt != 4'd0);
    assign o_digest_word  = r_obuf[255:224];
    assign o_word_index   = r_oidx;
    assign o_last_word    = (r_oidx == LAST_INDEX);

endmodule

### src/sha256_ctrl.sv
module sha256_ctrl
    import sha256_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_byte_present,
    input  logic    i_end_of_message,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [1:0] {F_IDLE, F_P80, F_PZERO, F_PLEN} t_feed_state;
    typedef enum logic [1:0] {C_IDLE, C_ROUND, C_FINISH, C_DIGEST} t_cmp_state;

    t_feed_state r_fst, n_fst;
    t_cmp_state  r_cst, n_cst;
    logic        r_full, n_full;
    logic        r_full_last, n_full_last;
    logic        r_cmp_last, n_cmp_last;
    logic [5:0]  r_round, n_round;
    logic        accept;

    assign o_in_ready = (r_fst == F_IDLE) && !r_full;
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        o_cmd       = '0;
        o_cmd.sel   = SEL_MSG;
        n_fst       = r_fst;
        n_cst       = r_cst;
        n_full      = r_full;
        n_full_last = r_full_last;
        n_cmp_last  = r_cmp_last;
        n_round     = r_round;

        // feed side: message bytes, then padding bytes
        case (r_fst)
            F_IDLE: begin
                if (accept && i_byte_present) begin
                    o_cmd.absorb = 1'b1;
                    o_cmd.count  = 1'b1;
                end
                if (accept && i_end_of_message) n_fst = F_P80;
            end
            F_P80: begin
                if (!r_full) begin
                    o_cmd.absorb = 1'b1;
                    o_cmd.sel    = SEL_PAD80;
                    n_fst        = F_PZERO;
                end
            end
            F_PZERO: begin
                if (!r_full) begin
                    if (i_sts.fill == LEN_START) begin
                        n_fst = F_PLEN;
                    end else begin
                        o_cmd.absorb = 1'b1;
                        o_cmd.sel    = SEL_ZERO;
                    end
                end
            end
            F_PLEN: begin
                if (!r_full) begin
                    o_cmd.absorb = 1'b1;
                    o_cmd.sel    = SEL_LEN;
                    if (i_sts.fill == LAST_SLOT) begin
                        o_cmd.clr_total = 1'b1;
                        n_fst           = F_IDLE;
                    end
                end
            end
            default: n_fst = F_IDLE;
        endcase

        if (o_cmd.absorb && i_sts.fill == LAST_SLOT) begin
            n_full      = 1'b1;
            n_full_last = (r_fst == F_PLEN);
        end

        // compression side: load, 64 rounds, fold into chaining words, then digest copy after a last block
        case (r_cst)
            C_IDLE: begin
                if (r_full) begin
                    o_cmd.load = 1'b1;
                    n_full     = 1'b0;
                    n_cmp_last = r_full_last;
                    n_round    = '0;
                    n_cst      = C_ROUND;
                end
            end
            C_ROUND: begin
                o_cmd.round     = 1'b1;
                o_cmd.round_idx = r_round;
                n_round         = r_round + 6'd1;
                if (r_round == LAST_ROUND) n_cst = C_FINISH;
            end
            C_FINISH: begin
                o_cmd.finish = 1'b1;
                n_cst        = r_cmp_last ? C_DIGEST : C_IDLE;
            end
            C_DIGEST: begin
                if (!i_sts.out_busy) begin
                    o_cmd.digest = 1'b1;
                    n_cst        = C_IDLE;
                end
            end
            default: n_cst = C_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fst       <= F_IDLE;
            r_cst       <= C_IDLE;
            r_full      <= 1'b0;
            r_full_last <= 1'b0;
            r_cmp_last  <= 1'b0;
            r_round     <= '0;
        end else begin
            r_fst       <= n_fst;
            r_cst       <= n_cst;
            r_full      <= n_full;
            r_full_last <= n_full_last;
            r_cmp_last  <= n_cmp_last;
            r_round     <= n_round;
        end
    end

    // a waiting block is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.absorb |-> !r_full)
        else $error("byte absorbed while a full block waits");

    // digest copy only into an empty output buffer
    a_digest_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.digest |-> !i_sts.out_busy)
        else $error("digest copied over pending output");

    // the last round is always followed by the fold step
    a_round_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cst == C_ROUND && r_round == LAST_ROUND) |=> (r_cst == C_FINISH))
        else $error("compression did not finish after last round");

    // a block full flag rises only when the last slot is written
    a_full_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_full) |-> $past(o_cmd.absorb) && ($past(i_sts.fill) == LAST_SLOT))
        else $error("block marked full without filling its last slot");

endmodule

### src/sha256_hash_unit.sv
// digest path: an end item gives its first digest word after its final padded block is
// loaded into the compressor (load, 64 rounds, fold, digest copy, the copy waiting for
// pending digest words); pad bytes go one per cycle while no full block waits, with an
// idle step ahead of the length field. throughput: one round per cycle; while no full
// block waits, bytes go one a cycle into a second block buffer as the last one compresses
// reset (synchronous, active low): chaining words to the initial hash, counts cleared,
// no digest pending
module sha256_hash_unit
    import sha256_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    sha256_in_if.sink   i_in,
    sha256_out_if.source o_out
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    sha256_ctrl u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in.valid),
        .i_byte_present   (i_in.byte_present),
        .i_end_of_message (i_in.end_of_message),
        .o_in_ready       (i_in.ready),
        .i_sts            (sts),
        .o_cmd            (cmd)
    );

    sha256_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_data_byte   (i_in.data_byte),
        .o_sts         (sts),
        .o_out_valid   (o_out.valid),
        .i_out_ready   (o_out.ready),
        .o_digest_word (o_out.digest_word),
        .o_word_index  (o_out.word_index),
        .o_last_word   (o_out.last_word)
    );

endmodule

### tb/sv/sha256_hash_unit_test.sv
`timescale 1ns / 1ps

module sha256_hash_unit_test;
    import sha256_pkg::*;

    localparam int          SINK_HOLD    = 800;
    localparam int          RANDOM_ITEMS = 180;
    localparam int          TAIL_CYCLES  = 200;
    localparam int          CYCLE_LIMIT  = 1000000;
    localparam int          EDGE_LENS [6] = '{55, 56, 63, 64, 119, 120};

    localparam logic [255:0] EMPTY_DIGEST =
        256'he3b0c44298fc1c149afbf4c8996fb92427ae41e4649b934ca495991b7852b855;
    localparam logic [255:0] ABC_DIGEST =
        256'hba7816bf8f01cfea414140de5dae2223b00361a396177a9cb410ff61f20015ad;

    typedef struct packed {
        logic [7:0]   data;
        logic         present;
        logic         eom;
        logic         known;
        logic [255:0] digest;
    } t_script_row;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  idx;
        logic        last;
    } t_digest_word;

    logic clk;
    logic rst_n;
    bit   hold_req;
    int   faults;
    int   cycles;

    sha256_in_if  in_ch ();
    sha256_out_if out_ch ();

    sha256_hash_unit dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // hasher state mirrored by the testbench
    logic [31:0] chain_h [8];
    logic [7:0]  blk [64];
    int          fill;
    logic [60:0] byte_total;

    t_digest_word digest_words_due [$];

    t_script_row script [16] = '{
        '{8'h00, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST},
        '{8'h61, 1'b1, 1'b0, 1'b0, 256'h0},
        '{8'h62, 1'b1, 1'b0, 1'b0, 256'h0},
        '{8'h63, 1'b1, 1'b1, 1'b1, ABC_DIGEST},
        '{8'h5a, 1'b0, 1'b0, 1'b0, 256'h0},
        '{8'hff, 1'b1, 1'b0, 1'b0, 256'h0},
        '{8'h00, 1'b1, 1'b0, 1'b0, 256'h0},
        '{8'ha5, 1'b0, 1'b0, 1'b0, 256'h0},
        '{8'h00, 1'b0, 1'b1, 1'b0, 256'h0},
        '{8'h80, 1'b1, 1'b1, 1'b0, 256'h0},
        '{8'hff, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST},
        '{8'h61, 1'b1, 1'b0, 1'b0, 256'h0},
        '{8'h62, 1'b1, 1'b0, 1'b0, 256'h0},
        '{8'h63, 1'b1, 1'b0, 1'b0, 256'h0},
        '{8'h3c, 1'b0, 1'b1, 1'b1, ABC_DIGEST},
        '{8'hff, 1'b1, 1'b1, 1'b0, 256'h0}
    };

    function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
        return (v >> n) | (v << (32 - n));
    endfunction

    function automatic void hash_compress();
        logic [31:0] w [64];
        logic [31:0] r [8];
        logic [31:0] t1, t2, x, y;
        int          i;
        for (i = 0; i < 16; i++) begin
            w[i] = {blk[4 * i], blk[4 * i + 1], blk[4 * i + 2], blk[4 * i + 3]};
        end
        for (i = 16; i < 64; i++) begin
            x = w[i - 15];
            y = w[i - 2];
            w[i] = w[i - 16] + (rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3)) + w[i - 7] +
                   (rotr(y, 17) ^ rotr(y, 19) ^ (y >> 10));
        end
        r = chain_h;
        for (i = 0; i < 64; i++) begin
            t1 = r[7] + (rotr(r[4], 6) ^ rotr(r[4], 11) ^ rotr(r[4], 25)) +
                 ((r[4] & r[5]) ^ (~r[4] & r[6])) + K[i] + w[i];
            t2 = (rotr(r[0], 2) ^ rotr(r[0], 13) ^ rotr(r[0], 22)) +
                 ((r[0] & r[1]) ^ (r[0] & r[2]) ^ (r[1] & r[2]));
            r[7] = r[6];
            r[6] = r[5];
            r[5] = r[4];
            r[4] = r[3] + t1;
            r[3] = r[2];
            r[2] = r[1];
            r[1] = r[0];
            r[0] = t1 + t2;
        end
        for (i = 0; i < 8; i++) begin
            chain_h[i] = chain_h[i] + r[i];
        end
    endfunction

    // absorbs one item; returns 1 with the digest when the item ends a message
    function automatic bit hash_absorb(input logic [7:0] data, input logic present,
                                       input logic eom, output logic [255:0] digest);
        logic [63:0] bit_len;
        int          i;
        digest = '0;
        if (present) begin
            blk[fill] = data;
            fill++;
            byte_total = byte_total + 61'd1;
            if (fill == 64) begin
                hash_compress();
                fill = 0;
            end
        end
        if (!eom) begin
            return 1'b0;
        end
        bit_len = {byte_total, 3'b000};
        blk[fill] = PAD_BYTE;
        fill++;
        // no room for the length field, spill into an extra block
        if (fill > 56) begin
            for (i = fill; i < 64; i++) begin
                blk[i] = 8'h00;
            end
            hash_compress();
            fill = 0;
        end
        for (i = fill; i < 56; i++) begin
            blk[i] = 8'h00;
        end
        for (i = 0; i < 8; i++) begin
            blk[56 + i] = bit_len[63 - 8 * i -: 8];
        end
        hash_compress();
        for (i = 0; i < 8; i++) begin
            digest[255 - 32 * i -: 32] = chain_h[i];
        end
        chain_h = IV;
        fill = 0;
        byte_total = '0;
        return 1'b1;
    endfunction

    function automatic void queue_digest(input logic [255:0] digest);
        int i;
        for (i = 0; i < 8; i++) begin
            digest_words_due.push_back(t_digest_word'{digest[255 - 32 * i -: 32], i[2:0],
                                                      i == 7});
        end
    endfunction

    function automatic int pick_gap(input bit burst);
        int r;
        r = $urandom_range(0, 99);
        if (burst || r < 55) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic void note_fault(input string msg);
        faults++;
        if (faults <= 10) begin
            $display("%s", msg);
        end
    endfunction

    bit src_burst;

    task automatic push_item(input logic [7:0] data, input logic present, input logic eom,
                             input logic known, input logic [255:0] known_digest);
        int           gap;
        logic [255:0] digest;
        gap = pick_gap(src_burst);
        repeat (gap) begin
            @(negedge clk);
            in_ch.valid = 1'b0;
        end
        @(negedge clk);
        in_ch.valid          = 1'b1;
        in_ch.data_byte      = data;
        in_ch.byte_present   = present;
        in_ch.end_of_message = eom;
        do begin
            @(posedge clk);
        end while (!in_ch.ready);
        if (hash_absorb(data, present, eom, digest)) begin
            queue_digest(known ? known_digest : digest);
        end
    endtask

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("sha256_hash_unit_test: errors");
            $finish;
        end
    end

    // digest word checker
    always @(posedge clk) begin
        t_digest_word want;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            if (digest_words_due.size() == 0) begin
                note_fault($sformatf("unexpected digest word %08h index %0d last %0b",
                                     out_ch.digest_word, out_ch.word_index,
                                     out_ch.last_word));
            end else begin
                want = digest_words_due.pop_front();
                if (out_ch.digest_word !== want.word || out_ch.word_index !== want.idx ||
                    out_ch.last_word !== want.last) begin
                    note_fault($sformatf("digest mismatch: want %08h/%0d/%0b got %08h/%0d/%0b",
                                         want.word, want.idx, want.last,
                                         out_ch.digest_word, out_ch.word_index,
                                         out_ch.last_word));
                end
            end
        end
    end

    // digest receiver with random back-pressure and one long hold-off
    initial begin
        int gap_left;
        int phase_left;
        bit burst;
        gap_left   = 0;
        phase_left = 0;
        burst      = 1'b0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (phase_left == 0) begin
                burst      = ($urandom_range(0, 2) == 0);
                phase_left = $urandom_range(50, 300);
            end
            phase_left--;
            if (hold_req && out_ch.valid) begin
                hold_req     = 1'b0;
                out_ch.ready = 1'b0;
                repeat (SINK_HOLD - 1) @(negedge clk);
            end else if (gap_left > 0) begin
                out_ch.ready = 1'b0;
                gap_left--;
            end else if (!burst && $urandom_range(0, 99) < 30) begin
                gap_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                       : $urandom_range(0, 2);
                out_ch.ready = 1'b0;
            end else begin
                out_ch.ready = 1'b1;
            end
        end
    end

    initial begin
        int n;
        int len;
        int items;
        int edge_pick;
        bit end_on_byte;
        chain_h    = IV;
        fill       = 0;
        byte_total = '0;
        faults     = 0;
        cycles     = 0;
        hold_req   = 1'b0;
        src_burst  = 1'b0;
        in_ch.valid          = 1'b0;
        in_ch.data_byte      = 8'h00;
        in_ch.byte_present   = 1'b0;
        in_ch.end_of_message = 1'b0;
        rst_n = 1'b0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        foreach (script[i]) begin
            src_burst = (i >= 11);
            push_item(script[i].data, script[i].present, script[i].eom,
                      script[i].known, script[i].digest);
        end

        // random messages; block-edge lengths are walked in turn
        hold_req  = 1'b1;
        items     = 0;
        edge_pick = 0;
        while (items < RANDOM_ITEMS) begin
            src_burst = ($urandom_range(0, 2) == 0);
            if ($urandom_range(0, 4) == 0) begin
                len       = EDGE_LENS[edge_pick];
                edge_pick = (edge_pick + 1) % 6;
            end else begin
                len = $urandom_range(0, 12);
            end
            end_on_byte = (len > 0) && ($urandom_range(0, 1) == 1);
            for (n = 0; n < len; n++) begin
                if ($urandom_range(0, 11) == 0) begin
                    push_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0, '0);
                end
                push_item(8'($urandom_range(0, 255)), 1'b1, end_on_byte && (n == len - 1),
                          1'b0, '0);
                items++;
            end
            if (!end_on_byte) begin
                push_item(8'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b0, '0);
                items++;
            end
        end
        @(negedge clk);
        in_ch.valid = 1'b0;

        while (digest_words_due.size() != 0) begin
            @(posedge clk);
        end
        repeat (TAIL_CYCLES) @(posedge clk);
        if (faults == 0) begin
            $display("sha256_hash_unit_test: clean");
        end else begin
            $display("sha256_hash_unit_test: errors");
        end
        $finish;
    end

endmodule
